FILE: hdl/peak_valley_run_counter_unit_defines.svh
// Assertion macros used by the checker of the peak and valley counter.
`ifndef PEAK_VALLEY_RUN_COUNTER_UNIT_DEFINES_SVH
`define PEAK_VALLEY_RUN_COUNTER_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define PVRC_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// A consequent that must follow in the same cycle as its antecedent.
`define PVRC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) else $error(msg);

// A consequent that must follow in the cycle after its antecedent.
`define PVRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) else $error(msg);

`endif

FILE: hdl/pvrc_pkg.sv
package pvrc_pkg;

  localparam int unsigned LEN_W     = 9;
  localparam int unsigned SAMPLE_W  = 31;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned DEFAULT_MAX_HALF_LEN = 256;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALLEY_LEN = 2'd1;

  // What the counting stage needs to know about one request besides the
  // flag line read data.
  typedef struct packed {
    logic first;
    logic peak_fwd;       // peak tap is the flag written by this request
    logic peak_fwd_flag;
    logic peak_live;      // peak tap lies inside the current series
    logic peak_fall_ok;   // falling run reached the peak half-width
    logic valley_fwd;
    logic valley_fwd_flag;
    logic valley_live;
    logic valley_rise_ok;
  } tap_ctrl_t;

endpackage

FILE: hdl/pvrc_if.sv
interface pvrc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          first;
  logic [pvrc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output first, output sample, input ready);
  modport sink   (input valid, input first, input sample, output ready);
endinterface

interface pvrc_out_if;
  logic                         valid;
  logic                         ready;
  logic [pvrc_pkg::COUNT_W-1:0] peak_count;
  logic [pvrc_pkg::COUNT_W-1:0] valley_count;

  modport source (output valid, output peak_count, output valley_count, input ready);
  modport sink   (input valid, input peak_count, input valley_count, output ready);
endinterface

interface pvrc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [pvrc_pkg::CFG_IDX_W-1:0] index;
  logic [pvrc_pkg::LEN_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pvrc_ram.sv
module pvrc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = pvrc_pkg::DEFAULT_MAX_HALF_LEN
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pvrc_front.sv
module pvrc_front #(
  parameter int unsigned MAX_HALF_LEN = pvrc_pkg::DEFAULT_MAX_HALF_LEN
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            first_i,
  input  logic [pvrc_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic [pvrc_pkg::LEN_W-1:0]      peak_len_i,
  input  logic [pvrc_pkg::LEN_W-1:0]      valley_len_i,
  output logic [$clog2(MAX_HALF_LEN)-1:0] wr_addr_o,
  output logic                            rise_flag_o,
  output logic                            fall_flag_o,
  output logic [$clog2(MAX_HALF_LEN)-1:0] rise_raddr_o,
  output logic [$clog2(MAX_HALF_LEN)-1:0] fall_raddr_o,
  output pvrc_pkg::tap_ctrl_t             tap_ctrl_o
);

  localparam int unsigned AW  = $clog2(MAX_HALF_LEN);
  localparam int unsigned AW1 = AW + 1;
  localparam int unsigned LW  = $clog2(MAX_HALF_LEN + 1);
  localparam int unsigned CW  = (LW > pvrc_pkg::LEN_W) ? LW : pvrc_pkg::LEN_W;

  logic [LW-1:0]                   rise_run_q, rise_run_d;
  logic [LW-1:0]                   fall_run_q, fall_run_d;
  logic [LW-1:0]                   fill_q, fill_d;
  logic [pvrc_pkg::SAMPLE_W-1:0]   last_q;
  logic [AW-1:0]                   pos_q, pos_d;
  logic [LW-1:0]                   peak_n, valley_m, peak_dly, valley_dly;
  pvrc_pkg::tap_ctrl_t             ctrl_d, ctrl_q;

  // A half-width of zero acts as one; above the line depth it saturates.
  function automatic logic [LW-1:0] eff_len(input logic [pvrc_pkg::LEN_W-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    if (ext == '0) begin
      return LW'(1);
    end else if (ext > CW'(MAX_HALF_LEN)) begin
      return LW'(MAX_HALF_LEN);
    end else begin
      return ext[LW-1:0];
    end
  endfunction

  function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] pos,
                                             input logic [AW-1:0] dly);
    logic [AW:0] wide;
    if (pos >= dly) begin
      wide = {1'b0, pos} - {1'b0, dly};
    end else begin
      wide = {1'b0, pos} + AW1'(MAX_HALF_LEN) - {1'b0, dly};
    end
    return wide[AW-1:0];
  endfunction

  always_comb begin
    peak_n     = eff_len(peak_len_i);
    valley_m   = eff_len(valley_len_i);
    peak_dly   = peak_n - LW'(1);
    valley_dly = valley_m - LW'(1);

    if (first_i) begin
      rise_run_d = LW'(1);
      fall_run_d = LW'(1);
      fill_d     = LW'(1);
    end else begin
      if (sample_i < last_q) begin
        rise_run_d = LW'(1);
      end else if (rise_run_q < LW'(MAX_HALF_LEN)) begin
        rise_run_d = rise_run_q + LW'(1);
      end else begin
        rise_run_d = rise_run_q;
      end
      if (sample_i > last_q) begin
        fall_run_d = LW'(1);
      end else if (fall_run_q < LW'(MAX_HALF_LEN)) begin
        fall_run_d = fall_run_q + LW'(1);
      end else begin
        fall_run_d = fall_run_q;
      end
      fill_d = (fill_q < LW'(MAX_HALF_LEN)) ? fill_q + LW'(1) : fill_q;
    end

    pos_d = (pos_q == AW'(MAX_HALF_LEN - 1)) ? '0 : pos_q + AW'(1);

    rise_flag_o = (rise_run_d >= peak_n);
    fall_flag_o = (fall_run_d >= valley_m);

    ctrl_d.first           = first_i;
    ctrl_d.peak_fwd        = (peak_dly == '0);
    ctrl_d.peak_fwd_flag   = rise_flag_o;
    ctrl_d.peak_live       = (peak_dly < fill_d);
    ctrl_d.peak_fall_ok    = (fall_run_d >= peak_n);
    ctrl_d.valley_fwd      = (valley_dly == '0);
    ctrl_d.valley_fwd_flag = fall_flag_o;
    ctrl_d.valley_live     = (valley_dly < fill_d);
    ctrl_d.valley_rise_ok  = (rise_run_d >= valley_m);
  end

  assign wr_addr_o    = pos_q;
  assign rise_raddr_o = tap_addr(pos_q, peak_dly[AW-1:0]);
  assign fall_raddr_o = tap_addr(pos_q, valley_dly[AW-1:0]);
  assign tap_ctrl_o   = ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_run_q <= '0;
      fall_run_q <= '0;
      fill_q     <= '0;
      last_q     <= '0;
      pos_q      <= '0;
    end else if (accept_i) begin
      rise_run_q <= rise_run_d;
      fall_run_q <= fall_run_d;
      fill_q     <= fill_d;
      last_q     <= sample_i;
      pos_q      <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ctrl_q <= ctrl_d;
    end
  end

endmodule

FILE: hdl/pvrc_count.sv
module pvrc_count (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  pvrc_pkg::tap_ctrl_t          tap_ctrl_i,
  input  logic                         rise_tap_i,
  input  logic                         fall_tap_i,
  output logic [pvrc_pkg::COUNT_W-1:0] peak_count_o,
  output logic [pvrc_pkg::COUNT_W-1:0] valley_count_o
);

  logic                         s1_valid_q, s1_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free, advance, accept;
  logic                         peak_hit, valley_hit;
  logic [pvrc_pkg::COUNT_W-1:0] peak_q, peak_d, peak_base;
  logic [pvrc_pkg::COUNT_W-1:0] valley_q, valley_d, valley_base;

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    advance    = s1_valid_q && out_free;
    in_ready_o = !s1_valid_q || out_free;
    accept     = in_valid_i && in_ready_o;

    s1_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
    out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

    peak_hit = tap_ctrl_i.peak_fall_ok &&
               (tap_ctrl_i.peak_fwd ? tap_ctrl_i.peak_fwd_flag
                                    : (tap_ctrl_i.peak_live && rise_tap_i));
    valley_hit = tap_ctrl_i.valley_rise_ok &&
                 (tap_ctrl_i.valley_fwd ? tap_ctrl_i.valley_fwd_flag
                                        : (tap_ctrl_i.valley_live && fall_tap_i));

    peak_base   = tap_ctrl_i.first ? '0 : peak_q;
    valley_base = tap_ctrl_i.first ? '0 : valley_q;
    peak_d      = (peak_hit && peak_base != '1) ?
                  peak_base + pvrc_pkg::COUNT_W'(1) : peak_base;
    valley_d    = (valley_hit && valley_base != '1) ?
                  valley_base + pvrc_pkg::COUNT_W'(1) : valley_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
      valley_q    <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        peak_q   <= peak_d;
        valley_q <= valley_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign peak_count_o   = peak_q;
  assign valley_count_o = valley_q;

endmodule

FILE: hdl/peak_valley_run_counter_unit.sv
// Peak and valley counter. The block takes one sample per cycle on in_i
// while results are taken and returns one result per sample on out_o with
// the running peak and valley counts of the current series; a sample with
// first set opens a new series. Each result passes the second stage and
// then the output register, which presents it on out_o. While a result
// waits in the output register, one more sample is taken into the second
// stage; after that the input stalls until the result is taken. The rate
// is set by the two flag line memories, each written and read once per
// sample. Series starts need no clearing pass: a fill count of samples
// since the series start marks which flag line entries belong to the
// current series, and the block is ready right after reset. The user
// writes half-widths on cfg_i while the block is idle; it is not enforced.
module peak_valley_run_counter_unit #(
  parameter int unsigned MAX_HALF_LEN = pvrc_pkg::DEFAULT_MAX_HALF_LEN
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pvrc_in_if.sink      in_i,
  pvrc_out_if.source   out_o,
  pvrc_cfg_if.sink     cfg_i
);

  localparam int unsigned AW = $clog2(MAX_HALF_LEN);

  logic [pvrc_pkg::LEN_W-1:0] peak_len_q;
  logic [pvrc_pkg::LEN_W-1:0] valley_len_q;

  logic                in_ready;
  logic                accept;
  logic [AW-1:0]       wr_addr, rise_raddr, fall_raddr;
  logic                rise_flag, fall_flag;
  logic                rise_tap, fall_tap;
  pvrc_pkg::tap_ctrl_t tap_ctrl;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_len_q   <= pvrc_pkg::LEN_W'(1);
      valley_len_q <= pvrc_pkg::LEN_W'(1);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pvrc_pkg::REG_PEAK_LEN:   peak_len_q   <= cfg_i.data;
        pvrc_pkg::REG_VALLEY_LEN: valley_len_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Run tracking, flag computation and flag line addressing.
  pvrc_front #(
    .MAX_HALF_LEN (MAX_HALF_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .first_i      (in_i.first),
    .sample_i     (in_i.sample),
    .peak_len_i   (peak_len_q),
    .valley_len_i (valley_len_q),
    .wr_addr_o    (wr_addr),
    .rise_flag_o  (rise_flag),
    .fall_flag_o  (fall_flag),
    .rise_raddr_o (rise_raddr),
    .fall_raddr_o (fall_raddr),
    .tap_ctrl_o   (tap_ctrl)
  );

  // Delay line of "rising run reached the peak half-width" flags. The tap
  // lies peak_len-1 samples back; a zero delay is forwarded, not read.
  pvrc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_HALF_LEN)
  ) u_rise_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_addr),
    .wdata_i (rise_flag),
    .re_i    (accept),
    .raddr_i (rise_raddr),
    .rdata_o (rise_tap)
  );

  // Delay line of "falling run reached the valley half-width" flags.
  pvrc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_HALF_LEN)
  ) u_fall_line (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wr_addr),
    .wdata_i (fall_flag),
    .re_i    (accept),
    .raddr_i (fall_raddr),
    .rdata_o (fall_tap)
  );

  // Second stage: pattern detection, saturating counts and the result
  // register with its handshake.
  pvrc_count u_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_ready),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .tap_ctrl_i     (tap_ctrl),
    .rise_tap_i     (rise_tap),
    .fall_tap_i     (fall_tap),
    .peak_count_o   (out_o.peak_count),
    .valley_count_o (out_o.valley_count)
  );

endmodule

FILE: hdl/pvrc_checker.sv
`include "peak_valley_run_counter_unit_defines.svh"

module pvrc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_first_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [pvrc_pkg::COUNT_W-1:0] peak_count_i,
  input logic [pvrc_pkg::COUNT_W-1:0] valley_count_i
);

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  // Requests accepted whose result has not been taken yet.
  always_comb begin
    in_acc  = in_valid_i && in_ready_i;
    out_acc = out_valid_i && out_ready_i;
    pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `PVRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, (out_valid_i && $stable(peak_count_i) && $stable(valley_count_i)), "stalled result changed")
  `PVRC_ASSERT_IMPLY(a_no_extra_result, clk_i, rst_ni, out_acc, (pend_q != 2'd0), "result without a request")
  `PVRC_ASSERT_ALWAYS(a_pend_bound, clk_i, rst_ni, pend_q != 2'd3, "more than two requests in flight")
  `PVRC_ASSERT_IMPLY(a_series_start, clk_i, rst_ni, in_acc && in_first_i && pend_q == 2'd0, ##2 (out_valid_i && peak_count_i <= 1 && valley_count_i <= 1), "series start result late or wrong")

endmodule

bind peak_valley_run_counter_unit pvrc_checker u_pvrc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_first_i     (in_i.first),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .peak_count_i   (out_o.peak_count),
  .valley_count_i (out_o.valley_count)
);

FILE: test/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the peak and valley counter.
//
// Sample requests are queued by the main initial block and presented on in_i
// by a driver that changes its outputs on the falling clock edge. A monitor
// on the rising edge sees every accepted request. For each one it computes
// the running peak and valley counts that the block must return, and it
// queues them. Each accepted result on out_o is then compared with the
// oldest queued count pair. The half-widths are written on cfg_i only while
// the block is drained, and the predictor takes each write at the edge that
// accepts it.
module tb;

  localparam int unsigned LEN_W     = pvrc_pkg::LEN_W;
  localparam int unsigned SAMPLE_W  = pvrc_pkg::SAMPLE_W;
  localparam int unsigned COUNT_W   = pvrc_pkg::COUNT_W;
  localparam int unsigned CFG_IDX_W = pvrc_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEN   = pvrc_pkg::REG_PEAK_LEN;
  localparam logic [CFG_IDX_W-1:0] REG_VALLEY_LEN = pvrc_pkg::REG_VALLEY_LEN;

  localparam int unsigned HALF_MAX    = pvrc_pkg::DEFAULT_MAX_HALF_LEN;
  localparam int unsigned POS_W       = $clog2(HALF_MAX);
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned PHASES      = 7;

  // Index 3 is not a register. A write to it must leave both half-widths alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  typedef struct packed {
    logic                first;
    logic [SAMPLE_W-1:0] sample;
  } sample_req_t;

  typedef struct packed {
    logic [COUNT_W-1:0] peaks;
    logic [COUNT_W-1:0] valleys;
  } counts_t;

  // Shapes of the sample stream that the generator strings together.
  typedef enum int {SEG_UP, SEG_DOWN, SEG_FLAT, SEG_NOISE} seg_kind_e;

  logic clk;
  logic rst_n;

  pvrc_in_if  in_if ();
  pvrc_out_if out_if ();
  pvrc_cfg_if cfg_if ();

  peak_valley_run_counter_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Predictor state. This is the bench's own copy of the block's state and
  // registers.
  logic [SAMPLE_W-1:0] prev_sample;
  logic [LEN_W-1:0]    up_run;
  logic [LEN_W-1:0]    down_run;
  logic [HALF_MAX-1:0] up_flags;
  logic [HALF_MAX-1:0] down_flags;
  logic [POS_W-1:0]    wr_pos;
  logic [COUNT_W-1:0]  peak_total;
  logic [COUNT_W-1:0]  valley_total;
  logic [LEN_W-1:0]    peak_half;
  logic [LEN_W-1:0]    valley_half;

  sample_req_t   sample_q[$];   // sample requests not yet presented
  counts_t       count_q[$];    // count pairs still owed by the block

  int unsigned   n_pushed;
  int unsigned   n_taken;
  int unsigned   errors;
  int unsigned   stuck_cycles;
  logic          in_taken;

  // Traffic shaping for the input and output sides.
  bit            jitter_on;
  bit            hold_req;
  int unsigned   hold_left;
  int unsigned   in_gap;
  int unsigned   out_stall;

  // The generator keeps the level of the series that it is building.
  logic [SAMPLE_W-1:0] gen_level;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A half-width of zero acts as one. Values above the line depth saturate.
  function automatic int unsigned half_width(logic [LEN_W-1:0] v);
    if (v == '0) return 1;
    if (v > HALF_MAX) return HALF_MAX;
    return v;
  endfunction

  // A run grows while the trend holds, saturating at the line depth. A break
  // restarts the run at the current sample.
  function automatic logic [LEN_W-1:0] run_step(logic [LEN_W-1:0] run, logic keep);
    if (!keep) return LEN_W'(1);
    return (run < HALF_MAX) ? run + LEN_W'(1) : run;
  endfunction

  task automatic predict_counts(input logic first, input logic [SAMPLE_W-1:0] s);
    int unsigned     n;
    int unsigned     m;
    logic [POS_W-1:0] peak_tap;
    logic [POS_W-1:0] valley_tap;
    counts_t         c;
    n = half_width(peak_half);
    m = half_width(valley_half);
    if (first) begin
      up_run       = LEN_W'(1);
      down_run     = LEN_W'(1);
      peak_total   = '0;
      valley_total = '0;
      up_flags     = '0;
      down_flags   = '0;
    end else begin
      // Right after reset both runs are zero. The first sample then restarts
      // them at one, which is the same as opening a series.
      up_run   = run_step(up_run, s >= prev_sample);
      down_run = run_step(down_run, s <= prev_sample);
    end
    prev_sample = s;
    // Each flag is judged against the half-width in force now. A later change
    // moves only the tap, never the stored flags.
    up_flags[wr_pos]   = (up_run >= n);
    down_flags[wr_pos] = (down_run >= m);
    // The tap sits half a window back. The window's rising half ended there,
    // and the falling half must cover everything since.
    peak_tap   = wr_pos - POS_W'(n - 1);
    valley_tap = wr_pos - POS_W'(m - 1);
    if (up_flags[peak_tap] && down_run >= n && peak_total != '1) begin
      peak_total = peak_total + COUNT_W'(1);
    end
    if (down_flags[valley_tap] && up_run >= m && valley_total != '1) begin
      valley_total = valley_total + COUNT_W'(1);
    end
    wr_pos    = wr_pos + POS_W'(1);
    c.peaks   = peak_total;
    c.valleys = valley_total;
    count_q.push_back(c);
  endtask

  // Monitor. It checks results first and predicts after that. No result can
  // come from the request accepted at the same edge.
  always @(posedge clk) begin : watch_ports
    counts_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (count_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request pending: expected none, %s %0d valleys %0d",
                   $time, "actual peaks", out_if.peak_count, out_if.valley_count);
        end else begin
          want = count_q.pop_front();
          if (out_if.peak_count !== want.peaks) begin
            errors++;
            $display("%0t: peak_count mismatch: expected %0d, actual %0d",
                     $time, want.peaks, out_if.peak_count);
          end
          if (out_if.valley_count !== want.valleys) begin
            errors++;
            $display("%0t: valley_count mismatch: expected %0d, actual %0d",
                     $time, want.valleys, out_if.valley_count);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        predict_counts(in_if.first, in_if.sample);
        n_taken++;
      end
      in_taken <= in_if.valid && in_if.ready;
    end
  end

  // Sample driver. A new request, or a gap, is chosen only once the one on
  // the bus has been taken. So valid stays high across back-to-back requests.
  always @(negedge clk) begin : drive_samples
    sample_req_t req;
    if (rst_n && (!in_if.valid || in_taken)) begin
      if (in_gap == 0 && jitter_on && $urandom_range(0, 3) == 0) begin
        in_gap = $urandom_range(1, 7);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        req = sample_q.pop_front();
        in_if.valid  <= 1'b1;
        in_if.first  <= req.first;
        in_if.sample <= req.sample;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver. A long hold is requested by the main block and counted
  // here. The sender keeps offering requests meanwhile, so the block fills up
  // and has to stall its input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 3) == 0) begin
        out_stall = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog. It ends the run once no channel has moved a request for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, STUCK_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic push_sample(input logic first, input logic [SAMPLE_W-1:0] s);
    sample_req_t req;
    req.first  = first;
    req.sample = s;
    sample_q.push_back(req);
    n_pushed++;
  endtask

  // Wait until every request has been taken and every result has come back.
  task automatic drain_results();
    while (n_taken != n_pushed || count_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_PEAK_LEN:   peak_half   = val;
      REG_VALLEY_LEN: valley_half = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Append len samples of the given shape, starting from the current level.
  // Small steps keep runs long. The odd large step, clamped at the ends of
  // the range, drives the level to zero and to the top value.
  task automatic push_segment(input seg_kind_e kind, input int len);
    int                  k;
    logic [SAMPLE_W:0]   wide;
    logic [SAMPLE_W-1:0] step;
    for (k = 0; k < len; k++) begin
      step = SAMPLE_W'($urandom_range(0, 3));
      if ($urandom_range(0, 15) == 0) step = SAMPLE_W'($urandom);
      case (kind)
        SEG_UP: begin
          wide      = {1'b0, gen_level} + {1'b0, step};
          gen_level = wide[SAMPLE_W] ? SAMPLE_MAX : wide[SAMPLE_W-1:0];
        end
        SEG_DOWN: gen_level = (step > gen_level) ? '0 : gen_level - step;
        SEG_FLAT: ;
        default: begin
          case ($urandom_range(0, 3))
            0:       gen_level = '0;
            1:       gen_level = SAMPLE_MAX;
            default: gen_level = SAMPLE_W'($urandom);
          endcase
        end
      endcase
      push_sample(1'b0, gen_level);
    end
  endtask

  // Build a stretch of ramps and plateaus with random content, around the
  // current half-widths. Some noise and some stray series starts break the
  // pattern now and then.
  task automatic make_series(input int count, input bit fresh, input int seg_max);
    int        done;
    int        seg;
    seg_kind_e kind;
    done = 0;
    if (fresh) begin
      gen_level = SAMPLE_W'($urandom);
      push_sample(1'b1, gen_level);
      done = 1;
    end
    while (done < count) begin
      seg = $urandom_range(1, seg_max);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = SEG_UP;
        4, 5, 6, 7: kind = SEG_DOWN;
        8:          kind = SEG_FLAT;
        default:    kind = SEG_NOISE;
      endcase
      if ($urandom_range(0, 39) == 0) begin
        push_sample(1'b1, gen_level);
        done++;
      end
      push_segment(kind, seg);
      done += seg;
    end
  endtask

  initial begin : run_test
    logic [LEN_W-1:0] peak_plan   [0:PHASES-1];
    logic [LEN_W-1:0] valley_plan [0:PHASES-1];
    int               p;
    int               seg_max;

    in_if.valid  = 1'b0;
    in_if.first  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_PEAK_LEN;
    cfg_if.data  = '0;

    prev_sample  = '0;
    up_run       = '0;
    down_run     = '0;
    up_flags     = '0;
    down_flags   = '0;
    wr_pos       = '0;
    peak_total   = '0;
    valley_total = '0;
    peak_half    = LEN_W'(1);
    valley_half  = LEN_W'(1);

    n_pushed     = 0;
    n_taken      = 0;
    errors       = 0;
    stuck_cycles = 0;
    in_taken     = 1'b0;
    jitter_on    = 1'b0;
    hold_req     = 1'b0;
    hold_left    = 0;
    in_gap       = 0;
    out_stall    = 0;
    gen_level    = '0;

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // With the reset half-widths of one, every sample is a peak and a valley.
    // The very first sample carries no series start and must open one anyway.
    push_sample(1'b0, SAMPLE_W'(5));
    push_sample(1'b0, SAMPLE_W'(5));
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b0, '0);
    push_sample(1'b1, SAMPLE_MAX);
    push_sample(1'b0, SAMPLE_MAX);
    push_sample(1'b0, SAMPLE_W'(31'h2AAA_AAAA));
    push_sample(1'b0, SAMPLE_W'(31'h5555_5555));
    drain_results();

    // Short peaks and valleys that are easy to follow by hand. The write to
    // the spare index must not disturb them.
    write_register(REG_PEAK_LEN, LEN_W'(2));
    write_register(REG_VALLEY_LEN, LEN_W'(3));
    write_register(REG_SPARE, LEN_W'(9'h155));
    push_sample(1'b1, SAMPLE_W'(10));
    push_sample(1'b0, SAMPLE_W'(11));
    push_sample(1'b0, SAMPLE_W'(12));
    push_sample(1'b0, SAMPLE_W'(12));
    push_sample(1'b0, SAMPLE_W'(11));
    push_sample(1'b0, SAMPLE_W'(10));
    push_sample(1'b0, SAMPLE_W'(10));
    push_sample(1'b0, SAMPLE_W'(11));
    push_sample(1'b0, SAMPLE_W'(12));
    drain_results();

    // Half-widths of zero act as one.
    write_register(REG_PEAK_LEN, '0);
    write_register(REG_VALLEY_LEN, '0);
    push_sample(1'b1, SAMPLE_W'(7));
    push_sample(1'b0, SAMPLE_W'(3));
    push_sample(1'b0, SAMPLE_W'(9));
    drain_results();

    // The peak half-width changes in the middle of a series. The old flags
    // stay and the tap moves at once.
    write_register(REG_PEAK_LEN, LEN_W'(3));
    push_sample(1'b0, SAMPLE_W'(4));
    push_sample(1'b0, SAMPLE_W'(5));
    push_sample(1'b0, SAMPLE_W'(6));
    push_sample(1'b0, SAMPLE_W'(5));
    push_sample(1'b0, SAMPLE_W'(4));
    drain_results();

    // The widest peak. The peak register is written as all ones and so
    // saturates, and the valley is at the full depth as well. One long series
    // rises, stays flat and falls, which saturates the runs and reaches every
    // entry of the flag lines.
    jitter_on = 1'b1;
    write_register(REG_PEAK_LEN, '1);
    write_register(REG_VALLEY_LEN, LEN_W'(HALF_MAX));
    gen_level = SAMPLE_W'(1000);
    push_sample(1'b1, gen_level);
    push_segment(SEG_UP, 130);
    push_segment(SEG_FLAT, 260);
    push_segment(SEG_DOWN, 130);
    drain_results();

    peak_plan   = '{9'd1, 9'd2, 9'd3, 9'd0, 9'd6, 9'd1, 9'd4};
    valley_plan = '{9'd1, 9'd2, 9'd5, 9'd4, 9'd2, 9'd1, 9'd3};
    peak_plan[5]   = LEN_W'($urandom_range(1, 8));
    valley_plan[5] = LEN_W'($urandom_range(1, 8));

    // Random phases. Odd phases carry on the series of the one before, so the
    // half-widths also change mid-series. The second phase holds the
    // receiver off for a long stretch. The last phase runs with no idling.
    // Each phase ends with the sender paused until all results are in.
    for (p = 0; p < PHASES; p++) begin
      write_register(REG_PEAK_LEN, peak_plan[p]);
      write_register(REG_VALLEY_LEN, valley_plan[p]);
      jitter_on = (p != PHASES - 1) && (p % 3 != 2);
      if (p == 1) hold_req = 1'b1;
      seg_max = half_width(peak_plan[p]);
      if (half_width(valley_plan[p]) > seg_max) seg_max = half_width(valley_plan[p]);
      make_series(30, p % 2 == 0, seg_max + 2);
      drain_results();
    end

    // Any extra result would show up in the monitor during this tail.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (count_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, count_q.size());
    end
    if (errors == 0 && count_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pvrc_pkg.sv
hdl/pvrc_if.sv
hdl/pvrc_ram.sv
hdl/pvrc_front.sv
hdl/pvrc_count.sv
hdl/peak_valley_run_counter_unit.sv
hdl/pvrc_checker.sv
test/tb.sv
